[hw/rtl/cmwc_random_generator_macros.svh]
// Assertion macros shared by the generator RTL.
// Both macros sample on the rising clock edge and are disabled while reset is low.
`ifndef CMWC_RANDOM_GENERATOR_MACROS_SVH
`define CMWC_RANDOM_GENERATOR_MACROS_SVH
`ifndef SYNTH
// The condition must hold at every clock edge.
`define CMWC_ASSERT(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// When the antecedent holds, the consequent must hold at the following clock edge.
`define CMWC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define CMWC_ASSERT(lbl, clk, rst_n, cond, msg)
`define CMWC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

[hw/rtl/cmwc_pkg.sv]
package cmwc_pkg;

  // Field widths of the channels.
  localparam int ACTION_W = 2;
  localparam int INDEX_W  = 12;
  localparam int WORD_W   = 32;

  // Action codes on the input channel.
  localparam logic [ACTION_W-1:0] ACT_LOAD_WORD  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_LOAD_CARRY = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_GENERATE   = 2'd2;

  // Status codes on the result channel.
  localparam logic STATUS_OK           = 1'b0;
  localparam logic STATUS_CARRY_REJECT = 1'b1;

  // Generator constants.
  localparam logic [14:0]       CMWC_MULT   = 15'd18782;
  localparam logic [WORD_W-1:0] CMWC_R      = 32'hffff_fffe;
  localparam logic [WORD_W-1:0] CARRY_LIMIT = 32'd809430660;
  localparam logic [WORD_W-1:0] CARRY_RESET = 32'd362436;

  // Decoded operation handed from the front end to the execute side.
  typedef enum logic [1:0] {
    OP_LOAD_WORD,
    OP_LOAD_CARRY,
    OP_GENERATE,
    OP_NONE
  } op_t;

  // One classified transaction as it sits in the queue.
  typedef struct packed {
    op_t                op;
    logic               idx_ok;
    logic               carry_bad;
    logic [INDEX_W-1:0] index;
    logic [WORD_W-1:0]  value;
  } item_t;

  // Execute side sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_FIN
  } back_state_t;

endpackage

[hw/rtl/cmwc_ifs.sv]
// Request channel: one action with its index and value per transaction.
interface cmwc_in_if;
  logic                              valid;
  logic                              ready;
  logic [cmwc_pkg::ACTION_W-1:0]     action;
  logic [cmwc_pkg::INDEX_W-1:0]      table_index;
  logic [cmwc_pkg::WORD_W-1:0]       load_value;

  modport source (output valid, output action, output table_index, output load_value,
                  input ready);
  modport sink   (input valid, input action, input table_index, input load_value,
                  output ready);
endinterface

// Result channel: one word and status per transaction.
interface cmwc_out_if;
  logic                          valid;
  logic                          ready;
  logic [cmwc_pkg::WORD_W-1:0]   random_word;
  logic                          status;

  modport source (output valid, output random_word, output status, input ready);
  modport sink   (input valid, input random_word, input status, output ready);
endinterface

[hw/rtl/cmwc_front.sv]
module cmwc_front #(
  parameter int TABLE_DEPTH = 4096
) (
  cmwc_in_if.sink          in_if,
  input  logic             q_full,
  output logic             push,
  output cmwc_pkg::item_t  push_item
);

  logic [31:0] idx_ext;

  // Accept whenever the queue has room.
  assign in_if.ready = !q_full;
  assign push        = in_if.valid && !q_full;

  assign idx_ext = {{(32 - cmwc_pkg::INDEX_W){1'b0}}, in_if.table_index};

  // Classify the action and precompute the range checks.
  always_comb begin
    unique case (in_if.action)
      cmwc_pkg::ACT_LOAD_WORD:  push_item.op = cmwc_pkg::OP_LOAD_WORD;
      cmwc_pkg::ACT_LOAD_CARRY: push_item.op = cmwc_pkg::OP_LOAD_CARRY;
      cmwc_pkg::ACT_GENERATE:   push_item.op = cmwc_pkg::OP_GENERATE;
      default:                  push_item.op = cmwc_pkg::OP_NONE;
    endcase
    push_item.idx_ok    = (idx_ext < 32'(TABLE_DEPTH));
    push_item.carry_bad = (in_if.load_value >= cmwc_pkg::CARRY_LIMIT);
    push_item.index     = in_if.table_index;
    push_item.value     = in_if.load_value;
  end

endmodule

[hw/rtl/cmwc_queue.sv]
`include "cmwc_random_generator_macros.svh"

module cmwc_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  cmwc_pkg::item_t  push_item,
  output logic             full,
  input  logic             pop,
  output logic             q_valid,
  output cmwc_pkg::item_t  q_item
);

  cmwc_pkg::item_t entries_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop_fire;

  assign full     = (cnt_r == 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = entries_r[rd_ptr_r];
  assign pop_fire = pop && q_valid;

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop_fire ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop_fire) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!push && pop_fire) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_item;
    end
  end

  `CMWC_ASSERT(a_cnt_max, clk, rst_n, cnt_r <= 2'd2, "queue count exceeds depth")
  `CMWC_ASSERT_NEXT(a_cnt_up, clk, rst_n, push && !pop_fire, cnt_r == $past(cnt_r) + 2'd1, "queue count missed a push")
  `CMWC_ASSERT_NEXT(a_cnt_down, clk, rst_n, pop_fire && !push, cnt_r == $past(cnt_r) - 2'd1, "queue count missed a pop")

endmodule

[hw/rtl/cmwc_back.sv]
`include "cmwc_random_generator_macros.svh"

module cmwc_back #(
  parameter int TABLE_DEPTH = 4096
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  cmwc_pkg::item_t  q_item,
  output logic             pop,
  cmwc_out_if.source       out_if
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam logic [AW-1:0] LAST = AW'(TABLE_DEPTH - 1);

  // Lag table.
  logic [31:0] mem [TABLE_DEPTH];
  logic [31:0] rd_data_r;

  cmwc_pkg::back_state_t state_r, state_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt, ptr_inc;
  logic [31:0]   carry_r, carry_nxt;
  logic [47:0]   prod_r, prod_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [31:0]   word_r, word_nxt;
  logic          status_r, status_nxt;

  logic          slot_free;
  logic          res_load;
  logic          rd_en;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [31:0]   mem_wdata;
  logic [31:0]   idx_ext;
  logic [AW-1:0] idx_addr;
  logic [31:0]   hi, sum, x, c_fix;
  logic          wrap;

  assign slot_free = !out_valid_r || out_if.ready;
  assign ptr_inc   = (ptr_r == LAST) ? '0 : ptr_r + 1'b1;
  assign idx_ext   = {{(32 - cmwc_pkg::INDEX_W){1'b0}}, q_item.index};
  assign idx_addr  = idx_ext[AW-1:0];

  // Carry fold of the registered product t = a*Q + c.
  assign hi    = {16'd0, prod_r[47:32]};
  assign sum   = prod_r[31:0] + hi;
  assign wrap  = (sum < hi);
  assign x     = wrap ? sum + 32'd1 : sum;
  assign c_fix = wrap ? hi + 32'd1 : hi;

  // Multiply the fetched lag word and add the carry.
  assign prod_nxt = 48'(cmwc_pkg::CMWC_MULT) * 48'(rd_data_r) + 48'(carry_r);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cmwc_pkg::ST_IDLE: begin
        if (q_valid && q_item.op == cmwc_pkg::OP_GENERATE) begin
          state_nxt = cmwc_pkg::ST_MUL;
        end
      end
      cmwc_pkg::ST_MUL: state_nxt = cmwc_pkg::ST_FIN;
      cmwc_pkg::ST_FIN: begin
        if (slot_free) begin
          state_nxt = cmwc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = cmwc_pkg::ST_IDLE;
    endcase
  end

  // State outputs: queue pop, table access, carry and result updates.
  always_comb begin
    pop        = 1'b0;
    rd_en      = 1'b0;
    res_load   = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = idx_addr;
    mem_wdata  = q_item.value;
    ptr_nxt    = ptr_r;
    carry_nxt  = carry_r;
    word_nxt   = 32'd0;
    status_nxt = cmwc_pkg::STATUS_OK;
    unique case (state_r)
      cmwc_pkg::ST_IDLE: begin
        if (q_valid) begin
          if (q_item.op == cmwc_pkg::OP_GENERATE) begin
            pop     = 1'b1;
            rd_en   = 1'b1;
            ptr_nxt = ptr_inc;
          end else if (slot_free) begin
            pop      = 1'b1;
            res_load = 1'b1;
            if (q_item.op == cmwc_pkg::OP_LOAD_WORD && q_item.idx_ok) begin
              mem_we = 1'b1;
            end
            if (q_item.op == cmwc_pkg::OP_LOAD_CARRY) begin
              if (q_item.carry_bad) begin
                status_nxt = cmwc_pkg::STATUS_CARRY_REJECT;
              end else begin
                carry_nxt = q_item.value;
              end
            end
          end
        end
      end
      cmwc_pkg::ST_MUL: begin
      end
      cmwc_pkg::ST_FIN: begin
        word_nxt  = cmwc_pkg::CMWC_R - x;
        mem_waddr = ptr_r;
        mem_wdata = cmwc_pkg::CMWC_R - x;
        if (slot_free) begin
          res_load  = 1'b1;
          mem_we    = 1'b1;
          carry_nxt = c_fix;
        end
      end
      default: begin
      end
    endcase
  end

  // Output register keeps the result until the sink takes it.
  always_comb begin
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.random_word = word_r;
  assign out_if.status      = status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cmwc_pkg::ST_IDLE;
      ptr_r       <= LAST;
      carry_r     <= cmwc_pkg::CARRY_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      carry_r     <= carry_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (res_load) begin
      word_r   <= word_nxt;
      status_r <= status_nxt;
    end
  end

  // Lag table write port and registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data_r <= mem[ptr_inc];
    end
  end

  `CMWC_ASSERT(a_ptr_range, clk, rst_n, ptr_r <= LAST, "table pointer out of range")
  `CMWC_ASSERT(a_carry_range, clk, rst_n, carry_r < cmwc_pkg::CARRY_LIMIT, "carry above limit")
  `CMWC_ASSERT_NEXT(a_mul_fin, clk, rst_n, state_r == cmwc_pkg::ST_MUL, state_r == cmwc_pkg::ST_FIN, "multiply step not followed by fold step")

endmodule

[hw/rtl/cmwc_random_generator.sv]
// Channel   Direction  Payload
// in_if     sink       action, table_index, load_value
// out_if    source     random_word, status
//
// A table or carry load completes in the idle state; a generate takes three steps
// (table read, multiply with carry add, carry fold and write back); the next starts
// only after the last is written back, set by the carry dependence through the lag
// table read. A two-entry queue separates intake from execution and a result register
// holds each result; a stall on one side blocks the other only once the queue fills.
// Reset (rst_n, synchronous) sets carry and pointer; the lag table is not cleared.
module cmwc_random_generator #(
  parameter int TABLE_DEPTH = 4096
) (
  input logic         clk,
  input logic         rst_n,
  cmwc_in_if.sink     in_if,
  cmwc_out_if.source  out_if
);

  logic            push;
  logic            q_full;
  logic            pop;
  logic            q_valid;
  cmwc_pkg::item_t push_item;
  cmwc_pkg::item_t q_item;

  // Request decode.
  cmwc_front #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_front (
    .in_if     (in_if),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  // Decoupling queue.
  cmwc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  // Execution and result register.
  cmwc_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_item  (q_item),
    .pop     (pop),
    .out_if  (out_if)
  );

endmodule
